// ===== design/hps_pkg.sv =====
`default_nettype none
package hps_pkg;

    // Sequencer stages, in the order the pulse train walks through them.
    typedef enum logic [2:0] {
        STAGE_IDLE     = 3'd0,
        STAGE_RESIST   = 3'd1,
        STAGE_REVERSE  = 3'd2,
        STAGE_CENTER   = 3'd3,
        STAGE_BUMP     = 3'd4,
        STAGE_RECOVERY = 3'd5
    } stage_t;

    // Motor command modes.
    localparam logic [1:0] MODE_FWD  = 2'd0;
    localparam logic [1:0] MODE_BWD  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    // Input operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Reset value of the recovery time in milliseconds.
    localparam logic [7:0] RECOVERY_RESET = 8'd50;

    typedef struct packed {
        logic              operation;
        logic signed [7:0] direction;
        logic        [7:0] strength;
        logic        [7:0] duration_base;
    } in_t;

    typedef struct packed {
        logic       drive_update;
        logic [1:0] drive_mode;
        logic [7:0] drive_level;
        logic [2:0] stage;
        logic       start_accepted;
    } out_t;

    // Floor of v / 5 via reciprocal multiply; exact for v below 4096.
    function automatic logic [10:0] div5(input logic [11:0] v);
        logic [24:0] p;
        p = 25'(v) * 25'd6554;
        return 11'(p[24:15]);
    endfunction

    // Floor of v / 10 via reciprocal multiply; exact for v below 4096.
    function automatic logic [10:0] div10(input logic [11:0] v);
        logic [23:0] p;
        p = 24'(v) * 24'd3277;
        return 11'(p[23:15]);
    endfunction

    // Clamp an 11-bit value to the 8-bit range.
    function automatic logic [7:0] sat8(input logic [10:0] v);
        return (v > 11'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/haptic_pulse_sequencer.sv =====
// Accepted transactions pass through the input register, then the result register.
// Throughput: one transaction per cycle unless m_ready stalls the result; the two
// registers let a new transaction enter while a finished result waits on m_ready.
// Reset: synchronous, active-low aresetn empties both registers, returns the
// sequencer to idle and sets recovery_ms to 50. No clearing pass is needed.
`default_nettype none
module haptic_pulse_sequencer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire hps_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output hps_pkg::out_t     m_data,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data
);

    hps_pkg::in_t  in_reg;
    logic          in_valid_reg, in_valid_next;
    hps_pkg::out_t out_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    recovery_reg;
    logic          advance;
    hps_pkg::out_t seq_result;

    // A held transaction moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    hps_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_reg),
        .recovery_ms (recovery_reg),
        .result      (seq_result)
    );

    // Handshake state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            recovery_reg  <= hps_pkg::RECOVERY_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                recovery_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= seq_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ===== design/hps_seq.sv =====
`default_nettype none
// Stage sequencer: holds the pulse-train state and computes the result of one
// transaction combinationally. State is committed when advance is high.
module hps_seq (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         advance,
    input  wire hps_pkg::in_t item,
    input  wire logic [7:0]   recovery_ms,
    output hps_pkg::out_t     result
);

    hps_pkg::stage_t stage_reg, stage_next;
    logic            dir_pos_reg, dir_pos_next;
    logic [7:0]      elapsed_reg, elapsed_next;
    logic [7:0]      str_reg [4];
    logic [7:0]      dur_reg [4];

    logic            load_start;
    logic            upd;
    logic [1:0]      mode;
    logic [7:0]      level;
    logic [7:0]      elapsed_inc;
    logic [1:0]      cur_idx;
    logic            start_dir_pos;
    logic [7:0]      start_str [4];
    logic [7:0]      start_dur [4];
    logic [11:0]     x_str;
    logic [11:0]     x_dur;

    // Scaled strengths and durations for a start transaction.
    always_comb begin
        x_str = 12'(item.strength);
        x_dur = 12'(item.duration_base);
        start_str[0] = hps_pkg::sat8(hps_pkg::div5(x_str * 12'd6));
        start_str[1] = hps_pkg::sat8(hps_pkg::div10(x_str * 12'd9));
        start_str[2] = item.strength >> 1;
        start_str[3] = hps_pkg::sat8(hps_pkg::div10(x_str * 12'd7));
        start_dur[0] = hps_pkg::sat8(hps_pkg::div5(x_dur * 12'd3));
        start_dur[1] = hps_pkg::sat8(hps_pkg::div10(x_dur * 12'd3));
        start_dur[2] = hps_pkg::sat8(hps_pkg::div5(x_dur * 12'd4));
        start_dur[3] = hps_pkg::sat8(hps_pkg::div5(x_dur * 12'd2));
        start_dir_pos = (item.direction > 8'sd0);
    end

    assign elapsed_inc = (elapsed_reg == 8'hFF) ? elapsed_reg : elapsed_reg + 8'd1;
    // Stages one to four map onto table entries zero to three.
    assign cur_idx     = 2'(stage_reg[1:0] - 2'd1);

    // Next-state logic.
    always_comb begin
        stage_next   = stage_reg;
        dir_pos_next = dir_pos_reg;
        elapsed_next = elapsed_reg;
        load_start   = 1'b0;
        if (item.operation == hps_pkg::OP_START) begin
            if (stage_reg == hps_pkg::STAGE_IDLE) begin
                load_start   = 1'b1;
                dir_pos_next = start_dir_pos;
                stage_next   = hps_pkg::STAGE_RESIST;
                elapsed_next = 8'd0;
            end
        end else if (stage_reg != hps_pkg::STAGE_IDLE) begin
            elapsed_next = elapsed_inc;
            unique case (stage_reg) inside
                hps_pkg::STAGE_RESIST, hps_pkg::STAGE_REVERSE,
                hps_pkg::STAGE_CENTER, hps_pkg::STAGE_BUMP: begin
                    if (elapsed_inc >= dur_reg[cur_idx]) begin
                        elapsed_next = 8'd0;
                        stage_next   = hps_pkg::stage_t'(stage_reg + 3'd1);
                    end
                end
                hps_pkg::STAGE_RECOVERY: begin
                    if (elapsed_inc >= recovery_ms) begin
                        elapsed_next = 8'd0;
                        stage_next   = hps_pkg::STAGE_IDLE;
                    end
                end
                default: begin
                    elapsed_next = 8'd0;
                    stage_next   = hps_pkg::STAGE_IDLE;
                end
            endcase
        end
    end

    // Command outputs: a command is issued whenever the stage changes.
    always_comb begin
        upd   = 1'b0;
        mode  = hps_pkg::MODE_FWD;
        level = 8'd0;
        if (load_start) begin
            upd   = 1'b1;
            // Resistance pushes against the movement.
            mode  = start_dir_pos ? hps_pkg::MODE_BWD : hps_pkg::MODE_FWD;
            level = start_str[0];
        end else if (stage_next != stage_reg) begin
            upd = 1'b1;
            unique case (stage_next)
                hps_pkg::STAGE_REVERSE, hps_pkg::STAGE_BUMP: begin
                    mode  = dir_pos_reg ? hps_pkg::MODE_FWD : hps_pkg::MODE_BWD;
                    level = str_reg[stage_reg[1:0]];
                end
                hps_pkg::STAGE_CENTER: begin
                    mode  = dir_pos_reg ? hps_pkg::MODE_BWD : hps_pkg::MODE_FWD;
                    level = str_reg[stage_reg[1:0]];
                end
                default: begin
                    mode  = hps_pkg::MODE_STOP;
                    level = 8'd0;
                end
            endcase
        end
        result.drive_update   = upd;
        result.drive_mode     = mode;
        result.drive_level    = level;
        result.stage          = stage_next;
        result.start_accepted = load_start;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg   <= hps_pkg::STAGE_IDLE;
            dir_pos_reg <= 1'b0;
            elapsed_reg <= 8'd0;
        end else if (advance) begin
            stage_reg   <= stage_next;
            dir_pos_reg <= dir_pos_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Stage tables, loaded by an accepted start.
    always_ff @(posedge aclk) begin
        if (advance && load_start) begin
            for (int i = 0; i < 4; i++) begin
                str_reg[i] <= start_str[i];
                dur_reg[i] <= start_dur[i];
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/hps_checker.sv =====
`default_nettype none
// Port-level checks on the sequencer's result channel.
module hps_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire hps_pkg::out_t m_data
);

    // An accepted start always issues a command and enters resistance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.start_accepted) |->
            (m_data.drive_update && m_data.stage == 3'(hps_pkg::STAGE_RESIST)))
        else $error("start accepted without resistance command");

    // Without a command, mode and level read zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.drive_update) |->
            (m_data.drive_mode == hps_pkg::MODE_FWD && m_data.drive_level == 8'd0))
        else $error("mode or level set without a command");

    // A stop command carries zero strength and leaves the sequence in recovery or idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.drive_mode == hps_pkg::MODE_STOP) |->
            (m_data.drive_level == 8'd0 &&
             (m_data.stage == 3'(hps_pkg::STAGE_RECOVERY) ||
              m_data.stage == 3'(hps_pkg::STAGE_IDLE))))
        else $error("stop command with strength or outside recovery");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind haptic_pulse_sequencer hps_checker u_hps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
